>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL. They expand to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
		else $error("%m: invariant violated");
// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> rtl/i2cseq_pkg.sv
// ---------------------------------------------------------------------------
// i2cseq_pkg
// Types, sizes and codes of the I2C master transaction sequencer.
// ---------------------------------------------------------------------------
package i2cseq_pkg;

	localparam int WRITE_DEPTH = 16;
	localparam int READ_DEPTH = 16;

	localparam int WIDX_W = $clog2(WRITE_DEPTH);
	localparam int WCNT_W = $clog2(WRITE_DEPTH + 1);
	localparam int RPOS_W = (READ_DEPTH > 1) ? $clog2(READ_DEPTH) : 1;
	localparam int RTGT_W = $clog2(READ_DEPTH + 1);
	localparam int RCMP_W = RTGT_W + 1;

	typedef enum logic [2:0] {
		FN_PUSH        = 3'd0,
		FN_START_WRITE = 3'd1,
		FN_START_READ  = 3'd2,
		FN_EVENT       = 3'd3,
		FN_RELEASE     = 3'd4
	} func_t;

	localparam logic [3:0] PH_IDLE     = 4'd0;
	localparam logic [3:0] PH_WRITE    = 4'd1;
	localparam logic [3:0] PH_STOP     = 4'd2;
	localparam logic [3:0] PH_ADDR_W   = 4'd3;
	localparam logic [3:0] PH_CMD      = 4'd4;
	localparam logic [3:0] PH_RESTART  = 4'd5;
	localparam logic [3:0] PH_ADDR_R   = 4'd6;
	localparam logic [3:0] PH_START_RX = 4'd7;
	localparam logic [3:0] PH_RX_ACK   = 4'd8;
	localparam logic [3:0] PH_RX_NACK  = 4'd9;
	localparam logic [3:0] PH_RESULT   = 4'd10;

	typedef enum logic [10:0] {
		ST_IDLE     = 11'b000_0000_0001,
		ST_WRITE    = 11'b000_0000_0010,
		ST_STOP     = 11'b000_0000_0100,
		ST_ADDR_W   = 11'b000_0000_1000,
		ST_CMD      = 11'b000_0001_0000,
		ST_RESTART  = 11'b000_0010_0000,
		ST_ADDR_R   = 11'b000_0100_0000,
		ST_START_RX = 11'b000_1000_0000,
		ST_RX_ACK   = 11'b001_0000_0000,
		ST_RX_NACK  = 11'b010_0000_0000,
		ST_RESULT   = 11'b100_0000_0000
	} state_t;

	typedef struct packed {
		logic [2:0] func;
		logic [7:0] push_byte;
		logic [4:0] expected_count;
		logic       tx_busy;
		logic       rx_full;
		logic [7:0] rx_data;
	} item_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       start_cond;
		logic       restart_cond;
		logic       stop_cond;
		logic       receive_enable;
		logic       send_ack;
		logic       ack_is_nack;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic [3:0] rx_index;
		logic [3:0] phase;
	} result_t;

	function automatic logic [3:0] phase_of(state_t s);
		logic [3:0] p;
		case (s)
			ST_IDLE:     p = PH_IDLE;
			ST_WRITE:    p = PH_WRITE;
			ST_STOP:     p = PH_STOP;
			ST_ADDR_W:   p = PH_ADDR_W;
			ST_CMD:      p = PH_CMD;
			ST_RESTART:  p = PH_RESTART;
			ST_ADDR_R:   p = PH_ADDR_R;
			ST_START_RX: p = PH_START_RX;
			ST_RX_ACK:   p = PH_RX_ACK;
			ST_RX_NACK:  p = PH_RX_NACK;
			ST_RESULT:   p = PH_RESULT;
			default:     p = PH_IDLE;
		endcase
		return p;
	endfunction

endpackage

>>> rtl/i2c_master_transaction_sequencer.sv
// ---------------------------------------------------------------------------
// i2c_master_transaction_sequencer
// Drives a byte-level I2C controller through write and register-read
// transactions, one step per input item.
// ---------------------------------------------------------------------------
// Usage:
// Items arrive on item/item_valid/item_stall; each is a push of a write byte,
// a start-write, a start-read, a controller event or a release. Every
// accepted item yields exactly one result on result/result_valid/
// result_stall, carrying the controller requests (load byte, start, repeated
// start, stop, receive enable, ack or nack), any received byte with its index,
// and the phase after the step.
// An item is registered on acceptance and processed once the output queue has
// room; then the state machine and the write store update and the result is
// written to a two-entry output queue, and result_valid rises with it. One
// item per cycle is sustained while the receiver keeps up.
// When the receiver stalls, results collect in the output queue; item_stall
// rises only once the queue is full and an item is waiting in the input
// register. Reset empties both stages and puts the sequencer in idle with all
// counters cleared; the write store contents are undefined until pushed.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module i2c_master_transaction_sequencer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  i2cseq_pkg::item_t   item,
	output logic                result_valid,
	input  logic                result_stall,
	output i2cseq_pkg::result_t result
);

	// Input register
	logic                valid_s1;
	i2cseq_pkg::item_t   item_s1;

	// Sequencer state
	i2cseq_pkg::state_t               st_q, st_d;
	logic [7:0]                       store_q [i2cseq_pkg::WRITE_DEPTH];
	logic [i2cseq_pkg::WCNT_W-1:0]    wcnt_q, wcnt_d;
	logic [i2cseq_pkg::WCNT_W-1:0]    wpos_q, wpos_d;
	logic [i2cseq_pkg::RPOS_W-1:0]    rpos_q, rpos_d;
	logic [i2cseq_pkg::RTGT_W-1:0]    rtgt_q, rtgt_d;
	logic                             isread_q, isread_d;
	logic                             store_we;

	// Output queue
	i2cseq_pkg::result_t obuf_q [2];
	logic                owr_q, ord_q;
	logic [1:0]          ocnt_q;

	i2cseq_pkg::result_t        res;
	logic                       take_in, fire, pop;
	logic [i2cseq_pkg::RPOS_W+3:0] rpos_ext;
	logic                       rx_last_done, read_cleared;

	assign take_in      = item_valid && !item_stall;
	assign fire         = valid_s1 && (ocnt_q != 2'd2);
	assign item_stall   = valid_s1 && (ocnt_q == 2'd2);
	assign result_valid = (ocnt_q != 2'd0);
	assign result       = obuf_q[ord_q];
	assign pop          = result_valid && !result_stall;
	assign rpos_ext     = {4'b0000, rpos_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= item;
		end
	end

	always_comb begin
		res      = '0;
		st_d     = st_q;
		wcnt_d   = wcnt_q;
		wpos_d   = wpos_q;
		rpos_d   = rpos_q;
		rtgt_d   = rtgt_q;
		isread_d = isread_q;
		store_we = 1'b0;
		case (item_s1.func)
			i2cseq_pkg::FN_PUSH: begin
				// Pushes beyond the store depth are silently dropped.
				if (wcnt_q < i2cseq_pkg::WCNT_W'(i2cseq_pkg::WRITE_DEPTH)) begin
					store_we = 1'b1;
					wcnt_d   = wcnt_q + i2cseq_pkg::WCNT_W'(1);
				end
			end
			i2cseq_pkg::FN_START_WRITE: begin
				isread_d       = 1'b0;
				st_d           = i2cseq_pkg::ST_WRITE;
				res.start_cond = 1'b1;
			end
			i2cseq_pkg::FN_START_READ: begin
				if (32'(item_s1.expected_count) > 32'(i2cseq_pkg::READ_DEPTH)) begin
					rtgt_d = i2cseq_pkg::RTGT_W'(i2cseq_pkg::READ_DEPTH);
				end else begin
					rtgt_d = i2cseq_pkg::RTGT_W'(item_s1.expected_count);
				end
				isread_d       = 1'b1;
				st_d           = i2cseq_pkg::ST_ADDR_W;
				res.start_cond = 1'b1;
			end
			i2cseq_pkg::FN_EVENT: begin
				if (isread_q) begin
					case (st_q)
						i2cseq_pkg::ST_ADDR_W: begin
							res.tx_valid = 1'b1;
							res.tx_byte  = store_q[0];
							st_d         = i2cseq_pkg::ST_CMD;
						end
						i2cseq_pkg::ST_CMD: begin
							res.tx_valid = 1'b1;
							res.tx_byte  = store_q[1];
							st_d         = i2cseq_pkg::ST_RESTART;
						end
						i2cseq_pkg::ST_RESTART: begin
							res.restart_cond = 1'b1;
							st_d             = i2cseq_pkg::ST_ADDR_R;
						end
						i2cseq_pkg::ST_ADDR_R: begin
							res.tx_valid = 1'b1;
							res.tx_byte  = store_q[0] | 8'h01;
							st_d         = i2cseq_pkg::ST_START_RX;
						end
						i2cseq_pkg::ST_START_RX: begin
							res.receive_enable = 1'b1;
							// The byte about to arrive is the last one when no
							// further index stays below the target.
							if ((i2cseq_pkg::RCMP_W'(rpos_q) + i2cseq_pkg::RCMP_W'(1))
									< i2cseq_pkg::RCMP_W'(rtgt_q)) begin
								st_d = i2cseq_pkg::ST_RX_ACK;
							end else begin
								st_d = i2cseq_pkg::ST_RX_NACK;
							end
						end
						i2cseq_pkg::ST_RX_ACK: begin
							if (item_s1.rx_full) begin
								res.rx_valid = 1'b1;
								res.rx_byte  = item_s1.rx_data;
								res.rx_index = rpos_ext[3:0];
								res.send_ack = 1'b1;
								rpos_d       = rpos_q + i2cseq_pkg::RPOS_W'(1);
								st_d         = i2cseq_pkg::ST_START_RX;
							end
						end
						i2cseq_pkg::ST_RX_NACK: begin
							if (item_s1.rx_full) begin
								res.rx_valid    = 1'b1;
								res.rx_byte     = item_s1.rx_data;
								res.rx_index    = rpos_ext[3:0];
								res.send_ack    = 1'b1;
								res.ack_is_nack = 1'b1;
								res.stop_cond   = 1'b1;
								wpos_d          = '0;
								wcnt_d          = '0;
								rpos_d          = '0;
								rtgt_d          = '0;
								st_d            = i2cseq_pkg::ST_RESULT;
							end
						end
						default: begin
						end
					endcase
				end else begin
					case (st_q)
						i2cseq_pkg::ST_WRITE: begin
							// Only the write phase waits for the transmitter.
							if (!item_s1.tx_busy) begin
								if (wpos_q < wcnt_q) begin
									res.tx_valid = 1'b1;
									res.tx_byte  = store_q[wpos_q[i2cseq_pkg::WIDX_W-1:0]];
									wpos_d       = wpos_q + i2cseq_pkg::WCNT_W'(1);
								end else begin
									res.stop_cond = 1'b1;
									st_d          = i2cseq_pkg::ST_STOP;
								end
							end
						end
						i2cseq_pkg::ST_STOP: begin
							wpos_d = '0;
							wcnt_d = '0;
							st_d   = i2cseq_pkg::ST_IDLE;
						end
						default: begin
						end
					endcase
				end
			end
			i2cseq_pkg::FN_RELEASE: begin
				st_d = i2cseq_pkg::ST_IDLE;
			end
			default: begin
			end
		endcase
		res.phase = i2cseq_pkg::phase_of(st_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= i2cseq_pkg::ST_IDLE;
			wcnt_q   <= '0;
			wpos_q   <= '0;
			rpos_q   <= '0;
			rtgt_q   <= '0;
			isread_q <= 1'b0;
		end else if (fire) begin
			st_q     <= st_d;
			wcnt_q   <= wcnt_d;
			wpos_q   <= wpos_d;
			rpos_q   <= rpos_d;
			rtgt_q   <= rtgt_d;
			isread_q <= isread_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && store_we) begin
			store_q[wcnt_q[i2cseq_pkg::WIDX_W-1:0]] <= item_s1.push_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= 1'b0;
			ord_q  <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (fire) begin
				owr_q <= ~owr_q;
			end
			if (pop) begin
				ord_q <= ~ord_q;
			end
			if (fire && !pop) begin
				ocnt_q <= ocnt_q + 2'd1;
			end else if (pop && !fire) begin
				ocnt_q <= ocnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			obuf_q[owr_q] <= res;
		end
	end

	// The last byte of a read has been taken and the transaction closes.
	assign rx_last_done = fire && isread_q && (item_s1.func == i2cseq_pkg::FN_EVENT)
		&& (st_q == i2cseq_pkg::ST_RX_NACK) && item_s1.rx_full;
	assign read_cleared = (rpos_q == '0) && (wcnt_q == '0)
		&& (st_q == i2cseq_pkg::ST_RESULT);

	`ASSERT_ALWAYS(a_wpos_within_count, clk, arst_n, wpos_q <= wcnt_q)
	`ASSERT_ALWAYS(a_queue_count_range, clk, arst_n, ocnt_q != 2'd3)
	`ASSERT_ALWAYS(a_rpos_within_depth, clk, arst_n, 32'(rpos_q) < i2cseq_pkg::READ_DEPTH)
	`ASSERT_NEXT(a_read_end_clears, clk, arst_n, rx_last_done, read_cleared)

endmodule
